// ===== sv/dcpm_pkg.sv =====
package dcpm_pkg;

  // Fixed field widths
  localparam int unsigned MaskW     = 32;
  localparam int unsigned LenW      = 6;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned MatchW    = 32;

  // Defaults for the top level parameters
  localparam int unsigned PatternMaxDef   = 32;
  localparam int unsigned PositionBitsDef = 32;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_MASK_A   = 3'd0,
    REG_MASK_C   = 3'd1,
    REG_MASK_G   = 3'd2,
    REG_MASK_T   = 3'd3,
    REG_PAT_LEN  = 3'd4
  } cfg_reg_e;

  // Text base codes
  typedef enum logic [1:0] {
    BASE_A = 2'd0,
    BASE_C = 2'd1,
    BASE_G = 2'd2,
    BASE_T = 2'd3
  } base_e;

  // Per-transfer control handed along the cell row
  typedef struct packed {
    logic advance;  // a text character is taken this cycle
    logic restart;  // it opens a new text: old prefixes are dropped
  } step_t;

endpackage

// ===== sv/dcpm_cell.sv =====
module dcpm_cell
  import dcpm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  step_t step_i,
  input  logic  link_i,   // prefix one position shorter, from the left neighbor
  input  logic  class_i,  // this position accepts the current character
  output logic  bit_d_o,  // prefix state after the current character
  output logic  bit_q_o   // prefix state handed to the right neighbor
);

  logic bit_q;
  logic bit_d;

  // Prefix extends only when the character fits this position
  assign bit_d = link_i & class_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else if (step_i.advance) begin
      bit_q <= bit_d;
    end
  end

  assign bit_d_o = bit_d;
  assign bit_q_o = bit_q;

endmodule

// ===== sv/dcpm_chain.sv =====
module dcpm_chain
  import dcpm_pkg::*;
#(
  parameter int unsigned Cells = PatternMaxDef,
  localparam int unsigned IdxW = (Cells > 1) ? $clog2(Cells) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  step_t            step_i,
  input  logic [Cells-1:0] class_i,
  input  logic [IdxW-1:0]  tap_i,   // last pattern position
  output logic             hit_o    // full pattern ends at the current character
);

  logic [Cells-1:0] link;
  logic [Cells-1:0] bit_d;
  logic [Cells-1:0] bit_q;

  // Row of prefix cells; position 0 always starts a new prefix
  for (genvar i = 0; i < Cells; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign link[i] = 1'b1;
    end else begin : g_body
      assign link[i] = bit_q[i-1] & ~step_i.restart;
    end

    dcpm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (step_i),
      .link_i  (link[i]),
      .class_i (class_i[i]),
      .bit_d_o (bit_d[i]),
      .bit_q_o (bit_q[i])
    );
  end

  // Tap at the pattern's last position
  assign hit_o = bit_d[tap_i];

endmodule

// ===== sv/dna_class_pattern_matcher_top.sv =====
// A result is registered into the output register when its input transfer is accepted.
// Throughput: one text base per cycle, set by the update of the
// prefix cell row; input stalls only while a result waits under output stall.
// Reset: masks clear to zero, pattern length to one, prefix bits and text
// position to zero; no result is pending. No clearing pass is needed.
module dna_class_pattern_matcher_top
  import dcpm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX   = PatternMaxDef,
  parameter int unsigned POSITION_BITS = PositionBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [MaskW-1:0]   cfg_wdata_i,
  // text input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         symbol_i,
  input  logic               not_base_i,
  input  logic               text_start_i,
  // match output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [MatchW-1:0]  match_start_o
);

  localparam int unsigned Cells = (PATTERN_MAX < MaskW) ? PATTERN_MAX : MaskW;
  localparam int unsigned IdxW  = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int unsigned DiffW = (POSITION_BITS > MatchW) ? POSITION_BITS : MatchW;
  localparam logic [POSITION_BITS-1:0] PosMax = '1;

  logic [MaskW-1:0]         mask_a_q, mask_c_q, mask_g_q, mask_t_q;
  logic [LenW-1:0]          len_q;
  logic [POSITION_BITS-1:0] pos_q, pos_d, pos_now;
  logic                     out_valid_q, out_valid_d;
  logic [MatchW-1:0]        match_q;
  logic [DiffW-1:0]         diff;
  logic [MaskW-1:0]         cls;
  logic [IdxW-1:0]          tap;
  logic                     acc, hit, saturated;
  step_t                    step;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_a_q <= '0;
      mask_c_q <= '0;
      mask_g_q <= '0;
      mask_t_q <= '0;
      len_q    <= LenW'(1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MASK_A:  mask_a_q <= cfg_wdata_i;
        REG_MASK_C:  mask_c_q <= cfg_wdata_i;
        REG_MASK_G:  mask_g_q <= cfg_wdata_i;
        REG_MASK_T:  mask_t_q <= cfg_wdata_i;
        REG_PAT_LEN: len_q    <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Effective last position: zero length acts as one, long lengths clamp
  always_comb begin
    if (len_q == '0) begin
      tap = '0;
    end else if ({1'b0, len_q} > (LenW+1)'(Cells)) begin
      tap = IdxW'(Cells - 1);
    end else begin
      tap = IdxW'(len_q - LenW'(1));
    end
  end

  // Class mask of the current character
  always_comb begin
    case (base_e'(symbol_i))
      BASE_A:  cls = mask_a_q;
      BASE_C:  cls = mask_c_q;
      BASE_G:  cls = mask_g_q;
      BASE_T:  cls = mask_t_q;
      default: cls = mask_t_q;
    endcase
    if (not_base_i) begin
      cls = '0;
    end
  end

  // Handshake: the output register frees when its result is taken
  assign in_stall_o   = out_valid_q & out_stall_i;
  assign acc          = in_valid_i & ~in_stall_o;
  assign step.advance = acc;
  assign step.restart = text_start_i;

  dcpm_chain #(
    .Cells (Cells)
  ) u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .class_i (cls[Cells-1:0]),
    .tap_i   (tap),
    .hit_o   (hit)
  );

  // Text position with saturation
  assign pos_now   = text_start_i ? '0 : pos_q;
  assign saturated = (pos_now == PosMax);
  assign pos_d     = saturated ? pos_now : pos_now + POSITION_BITS'(1);
  assign diff      = DiffW'(pos_now) - DiffW'(tap);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (acc) begin
      pos_q <= pos_d;
    end
  end

  // Output register
  assign out_valid_d = acc ? (hit & ~saturated) : (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && hit && !saturated) begin
      match_q <= diff[MatchW-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign match_start_o = match_q;

  // Checks
  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  a_restart_position : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && text_start_i) |=> (pos_q == POSITION_BITS'(1)))
    else $error("position not one after text start");

  a_restart_match_at_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && text_start_i && hit) |=> (match_start_o == '0))
    else $error("match on first character not at position zero");

  a_non_base_breaks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && not_base_i) |-> !hit)
    else $error("non-base character completed a match");

endmodule
